### sv/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants for the servo slew sequencer: request codes,
// modes, field widths, the constant-divide reciprocal and the structs that
// pass between the configuration block and the core.
// ----------------------------------------------------------------------------
package ssq_pkg;

	// field widths
	localparam int unsigned ANGLE_W    = 8;
	localparam int unsigned DUR_W      = 15;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned STEP_W     = 6;
	localparam int unsigned REQ_W      = 3;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = DUR_W;

	// default number of steps per move (range 1 to 63)
	localparam int unsigned STEPS_DEF = 32;

	// divide by STEPS through a reciprocal: floor(n * RECIP >> DIV_SHIFT)
	// is exact for n below 2**15 and any step count up to 63
	localparam int unsigned DIV_SHIFT = 21;
	localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
	localparam int unsigned RM_W      = ANGLE_W + RECIP_W;

	// register reset values
	localparam int unsigned ANGLE_LOW_RST  = 0;
	localparam int unsigned ANGLE_HIGH_RST = 180;
	localparam int unsigned SLOW_DUR_RST   = 1000;
	localparam int unsigned FAST_DUR_RST   = 1000;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 3'd0,
		REQ_SET   = 3'd1,
		REQ_START = 3'd2,
		REQ_STOP  = 3'd3,
		REQ_LOAD  = 3'd4
	} req_t;

	// operating modes
	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_READY  = 2'd1,
		MODE_MOVING = 2'd2
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE_LOW  = 8'd0,
		CFG_ANGLE_HIGH = 8'd1,
		CFG_SLOW_DUR   = 8'd2,
		CFG_FAST_DUR   = 8'd3
	} cfg_idx_t;

	// configuration as seen by the core, with precomputed divides
	typedef struct packed {
		logic [ANGLE_W-1:0] angle_low;
		logic [ANGLE_W-1:0] angle_high;
		logic               range_neg;
		logic [RM_W-1:0]    range_rm;
		logic [DUR_W-1:0]   slow_step_ms;
		logic [DUR_W-1:0]   fast_step_ms;
	} cfg_t;

	// one input item
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [TIME_W-1:0] now_ms;
		logic              target_position;
		logic              fast_rate;
	} item_t;

	// one result item
	typedef struct packed {
		logic               drive_valid;
		logic [ANGLE_W-1:0] drive_angle;
		logic               pwm_enabled;
		logic               is_moving;
		logic               move_done;
	} result_t;

endpackage

### sv/ssq_cfg.sv
// ----------------------------------------------------------------------------
// ssq_cfg
// Configuration registers. On each write the signed angle range times the
// step reciprocal and the per-step durations are worked out and stored, so
// the core only needs one small multiply per item.
// ----------------------------------------------------------------------------
module ssq_cfg
	import ssq_pkg::*;
#(
	parameter int unsigned STEPS = STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	localparam int unsigned RECIP    = ((2 ** DIV_SHIFT) + STEPS - 1) / STEPS;
	localparam int unsigned DPROD_W  = DUR_W + RECIP_W;
	localparam bit          NEG_RST  = ANGLE_HIGH_RST < ANGLE_LOW_RST;
	localparam int unsigned MAG_RST  = NEG_RST ? (ANGLE_LOW_RST - ANGLE_HIGH_RST)
	                                           : (ANGLE_HIGH_RST - ANGLE_LOW_RST);
	localparam longint unsigned RM_RST_L = longint'(MAG_RST) * longint'(RECIP);
	localparam logic [RM_W-1:0]  RM_RST  = RM_W'(RM_RST_L);
	localparam logic [DUR_W-1:0] SLOW_STEP_RST = DUR_W'(SLOW_DUR_RST / STEPS);
	localparam logic [DUR_W-1:0] FAST_STEP_RST = DUR_W'(FAST_DUR_RST / STEPS);

	logic [ANGLE_W-1:0] angle_low_q;
	logic [ANGLE_W-1:0] angle_high_q;
	logic               range_neg_q;
	logic [RM_W-1:0]    range_rm_q;
	logic [DUR_W-1:0]   slow_step_q;
	logic [DUR_W-1:0]   fast_step_q;

	logic [ANGLE_W-1:0] new_low;
	logic [ANGLE_W-1:0] new_high;
	logic [ANGLE_W:0]   diff;
	logic [ANGLE_W:0]   diff_neg;
	logic [ANGLE_W-1:0] mag;
	logic [RM_W-1:0]    rm_next;
	logic [DPROD_W-1:0] dur_prod;
	logic [DUR_W-1:0]   dur_step;

	// range of the end angles after this write
	always_comb begin
		new_low  = angle_low_q;
		new_high = angle_high_q;
		if (wr_index == CFG_ANGLE_LOW) begin
			new_low = wr_data[ANGLE_W-1:0];
		end
		if (wr_index == CFG_ANGLE_HIGH) begin
			new_high = wr_data[ANGLE_W-1:0];
		end
		diff     = {1'b0, new_high} - {1'b0, new_low};
		diff_neg = ~diff + {{ANGLE_W{1'b0}}, 1'b1};
		mag      = diff[ANGLE_W] ? diff_neg[ANGLE_W-1:0] : diff[ANGLE_W-1:0];
		rm_next  = RM_W'(mag) * RM_W'(RECIP);
	end

	// written duration divided by the step count
	assign dur_prod = DPROD_W'(wr_data) * DPROD_W'(RECIP);
	assign dur_step = dur_prod[DIV_SHIFT +: DUR_W];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_low_q  <= ANGLE_W'(ANGLE_LOW_RST);
			angle_high_q <= ANGLE_W'(ANGLE_HIGH_RST);
			range_neg_q  <= NEG_RST;
			range_rm_q   <= RM_RST;
			slow_step_q  <= SLOW_STEP_RST;
			fast_step_q  <= FAST_STEP_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ANGLE_LOW, CFG_ANGLE_HIGH: begin
					angle_low_q  <= new_low;
					angle_high_q <= new_high;
					range_neg_q  <= diff[ANGLE_W];
					range_rm_q   <= rm_next;
				end
				CFG_SLOW_DUR: begin
					slow_step_q <= dur_step;
				end
				CFG_FAST_DUR: begin
					fast_step_q <= dur_step;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.angle_low    = angle_low_q;
	assign cfg.angle_high   = angle_high_q;
	assign cfg.range_neg    = range_neg_q;
	assign cfg.range_rm     = range_rm_q;
	assign cfg.slow_step_ms = slow_step_q;
	assign cfg.fast_step_ms = fast_step_q;

endmodule

### sv/ssq_core.sv
// ----------------------------------------------------------------------------
// ssq_core
// Mode, position, rate, due time and step counter, and the single-pass
// update that turns one request into one result.
// ----------------------------------------------------------------------------
module ssq_core
	import ssq_pkg::*;
#(
	parameter int unsigned STEPS = STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int unsigned PROD_W = RM_W + STEP_W;

	mode_t              mode_q, mode_d;
	logic               pos_q, pos_d;
	logic               rate_q, rate_d;
	logic [TIME_W-1:0]  due_q, due_d;
	logic [STEP_W-1:0]  step_q, step_d;

	logic [STEP_W-1:0]  step_inc;
	logic [PROD_W-1:0]  prod;
	logic [ANGLE_W-1:0] inc;
	logic [ANGLE_W-1:0] up_angle;
	logic [ANGLE_W-1:0] dn_angle;
	logic [DUR_W-1:0]   step_ms;
	logic [TIME_W-1:0]  due_next;
	logic               tick_due;

	// angle of the current step: trunc((k+1)*range/STEPS)
	assign step_inc = step_q + {{(STEP_W-1){1'b0}}, 1'b1};
	assign prod     = PROD_W'(step_inc) * PROD_W'(cfg.range_rm);
	assign inc      = prod[DIV_SHIFT +: ANGLE_W];
	assign up_angle = cfg.range_neg ? (cfg.angle_low - inc) : (cfg.angle_low + inc);
	assign dn_angle = cfg.range_neg ? (cfg.angle_high + inc) : (cfg.angle_high - inc);

	// next due time and tick test
	assign step_ms  = rate_q ? cfg.fast_step_ms : cfg.slow_step_ms;
	assign due_next = item.now_ms + TIME_W'(step_ms);
	assign tick_due = (mode_q == MODE_MOVING) && (item.now_ms > due_q);

	// request decode and next state
	always_comb begin
		mode_d = mode_q;
		pos_d  = pos_q;
		rate_d = rate_q;
		due_d  = due_q;
		step_d = step_q;
		res    = '0;
		case (item.req_type)
			REQ_TICK: begin
				if (tick_due) begin
					due_d = due_next;
					if (step_q < STEP_W'(STEPS)) begin
						res.drive_valid = 1'b1;
						res.drive_angle = pos_q ? up_angle : dn_angle;
						step_d          = step_inc;
					end else begin
						step_d        = '0;
						mode_d        = MODE_READY;
						res.move_done = 1'b1;
					end
				end
			end
			REQ_SET: begin
				if (item.target_position != pos_q && mode_q == MODE_READY) begin
					pos_d  = item.target_position;
					rate_d = item.fast_rate;
					mode_d = MODE_MOVING;
				end
			end
			REQ_START: begin
				if (mode_q == MODE_OFF) begin
					res.drive_valid = 1'b1;
					res.drive_angle = pos_q ? cfg.angle_high : cfg.angle_low;
					mode_d          = MODE_READY;
				end
			end
			REQ_STOP: begin
				if (mode_q == MODE_READY) begin
					mode_d = MODE_OFF;
				end
			end
			REQ_LOAD: begin
				pos_d = item.target_position;
			end
			default: begin
			end
		endcase
		res.pwm_enabled = (mode_d != MODE_OFF);
		res.is_moving   = (mode_d == MODE_MOVING);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			pos_q  <= 1'b0;
			rate_q <= 1'b0;
			due_q  <= '0;
			step_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			rate_q <= rate_d;
			due_q  <= due_d;
			step_q <= step_d;
		end
	end

endmodule

### sv/servo_slew_sequencer.sv
// ----------------------------------------------------------------------------
// servo_slew_sequencer
// Two-position servo slew sequencer. Takes one request item per clock while
// in_stall is low and gives one result item per request, through the input
// register, then the result register. All work for an item is one pass through
// the core between those registers, and the core's state is updated in the
// same cycle, so the next item follows without a gap; while the previous result
// waits to be taken, the input register can still take one new item. Step
// angles and per-step times come from divides by STEPS that are worked out
// when a configuration register is written; the configuration port is
// always ready.
// ----------------------------------------------------------------------------
module servo_slew_sequencer
	import ssq_pkg::*;
#(
	parameter int unsigned STEPS = STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  target_position,
	input  logic                  fast_rate,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  drive_valid,
	output logic [ANGLE_W-1:0]    drive_angle,
	output logic                  pwm_enabled,
	output logic                  is_moving,
	output logic                  move_done,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    fire;

	// configuration registers
	assign cfg_ready = 1'b1;

	ssq_cfg #(
		.STEPS(STEPS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid & cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// flow control: stage 1 moves on when the result register is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.req_type        <= req_type;
			item_s1.now_ms          <= now_ms;
			item_s1.target_position <= target_position;
			item_s1.fast_rate       <= fast_rate;
		end
	end

	// state and request handling
	ssq_core #(
		.STEPS(STEPS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_valid = res_q.drive_valid;
	assign drive_angle = res_q.drive_angle;
	assign pwm_enabled = res_q.pwm_enabled;
	assign is_moving   = res_q.is_moving;
	assign move_done   = res_q.move_done;

endmodule
